// ===== rtl/mm3_pkg.sv =====
`default_nettype none

package mm3_pkg;

  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 3;
  localparam int WORD_BYTES = 4;

  localparam logic [WORD_W-1:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [WORD_W-1:0] MIX_C2 = 32'h1b873593;
  localparam logic [WORD_W-1:0] MIX_N  = 32'he6546b64;
  localparam logic [WORD_W-1:0] MIX_M  = 32'd5;
  localparam logic [WORD_W-1:0] FIN_C1 = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] FIN_C2 = 32'hc2b2ae35;

  localparam logic [COUNT_W-1:0] CNT_NONE = 3'd0;
  localparam logic [COUNT_W-1:0] CNT_FULL = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCR1,
    ST_SCR2,
    ST_TAIL,
    ST_MIX5,
    ST_ADDN,
    ST_FIN1,
    ST_FIN2,
    ST_EMIT
  } state_t;

  // One request to the shared multiplier.
  typedef struct packed {
    logic              go;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
    return {x[18:0], x[31:19]};
  endfunction

  // Keeps only the valid low bytes of a tail word.
  function automatic logic [WORD_W-1:0] tail_mask(input logic [WORD_W-1:0] w,
                                                  input logic [COUNT_W-1:0] cnt);
    logic [WORD_W-1:0] m;
    case (cnt)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return w & m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mm3_if.sv =====
`default_nettype none

interface mm3_in_if;
  logic                         valid;
  logic                         ready;
  logic [mm3_pkg::WORD_W-1:0]   data_word;
  logic [mm3_pkg::COUNT_W-1:0]  byte_count;
  logic                         last_word;

  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface mm3_out_if;
  logic                       valid;
  logic                       ready;
  logic [mm3_pkg::WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/mm3_mul.sv =====
`default_nettype none

module mm3_mul (
  input  logic                       clk,
  input  mm3_pkg::mul_req_t          req,
  output logic [mm3_pkg::WORD_W-1:0] prod
);
  import mm3_pkg::*;

  // Low half of the product; the register holds while no request is issued.
  always_ff @(posedge clk) begin
    if (req.go) begin
      prod <= req.a * req.b;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/murmur3_32_key_hasher_unit.sv =====
// Channel    Dir   Payload                               Handshake
// key_in     in    data_word[31:0] byte_count[2:0] last  valid/ready
// hash_out   out   hash_value[31:0]                      valid/ready
// seed_*     in    seed_wdata[31:0]                      seed_we, no wait
//
// A full word takes the accept, three passes through the one shared
// multiplier and the final add; a tail word the accept, the scramble and
// the XOR; a zero-byte last word the accept. A last word adds finalization.
// Reset clears the control state and the seed. A finished hash waits in
// the output register; the next word is accepted meanwhile, and only the
// next finalization stalls on a full output register.
`default_nettype none

module murmur3_32_key_hasher_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  mm3_in_if.sink                     key_in,
  mm3_out_if.source                  hash_out,
  input  logic                       seed_we,
  input  logic [mm3_pkg::WORD_W-1:0] seed_wdata
);
  import mm3_pkg::*;

  state_t                 state, state_next;
  logic [WORD_W-1:0]      seed;
  logic [WORD_W-1:0]      k_word;
  logic [COUNT_W-1:0]     cnt;
  logic                   last_q;
  logic [WORD_W-1:0]      running_hash;
  logic [LENGTH_BITS-1:0] byte_length;
  logic                   key_start;
  logic                   out_valid;
  logic [WORD_W-1:0]      out_hash;

  logic [WORD_W-1:0]      prod;
  mul_req_t               mul_req;
  logic                   in_accept;
  logic [COUNT_W-1:0]     cnt_eff;
  logic                   slot_free;
  logic                   fin_load;
  logic [WORD_W-1:0]      fin_x;

  mm3_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign in_accept = key_in.valid && key_in.ready;
  assign slot_free = !out_valid || hash_out.ready;
  assign fin_load  = (state == ST_EMIT) && slot_free;
  assign fin_x     = running_hash ^ WORD_W'(byte_length);

  // Words before the last always count as four bytes.
  always_comb begin
    if (!key_in.last_word || key_in.byte_count > CNT_FULL) begin
      cnt_eff = CNT_FULL;
    end else begin
      cnt_eff = key_in.byte_count;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (cnt_eff == CNT_NONE) ? ST_FIN1 : ST_SCR1;
        end
      end
      ST_SCR1: state_next = ST_SCR2;
      ST_SCR2: state_next = (cnt == CNT_FULL) ? ST_MIX5 : ST_TAIL;
      ST_TAIL: state_next = ST_FIN1;
      ST_MIX5: state_next = ST_ADDN;
      ST_ADDN: state_next = last_q ? ST_FIN1 : ST_IDLE;
      ST_FIN1: state_next = ST_FIN2;
      ST_FIN2: state_next = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    key_in.ready = 1'b0;
    mul_req      = '{go: 1'b0, a: k_word, b: MIX_C1};
    case (state)
      ST_IDLE: key_in.ready = 1'b1;
      ST_SCR1: mul_req = '{go: 1'b1, a: k_word, b: MIX_C1};
      ST_SCR2: mul_req = '{go: 1'b1, a: rotl15(prod), b: MIX_C2};
      ST_MIX5: mul_req = '{go: 1'b1, a: rotl13(running_hash ^ prod), b: MIX_M};
      ST_FIN1: mul_req = '{go: 1'b1, a: fin_x ^ (fin_x >> 16), b: FIN_C1};
      ST_FIN2: mul_req = '{go: 1'b1, a: prod ^ (prod >> 13), b: FIN_C2};
      default: mul_req = '{go: 1'b0, a: k_word, b: MIX_C1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seed      <= '0;
      key_start <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (seed_we) begin
        seed <= seed_wdata;
      end
      if (in_accept) begin
        key_start <= 1'b0;
      end else if (state == ST_FIN1) begin
        key_start <= 1'b1;
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (hash_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      byte_length  <= '0;
    end else begin
      if (in_accept) begin
        if (key_start) begin
          running_hash <= seed;
          byte_length  <= LENGTH_BITS'(cnt_eff);
        end else begin
          byte_length  <= byte_length + LENGTH_BITS'(cnt_eff);
        end
      end else if (state == ST_TAIL) begin
        running_hash <= running_hash ^ prod;
      end else if (state == ST_ADDN) begin
        running_hash <= prod + MIX_N;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      k_word <= tail_mask(key_in.data_word, cnt_eff);
      cnt    <= cnt_eff;
      last_q <= key_in.last_word;
    end
  end

  // The multiplier is idle while EMIT waits, so the last product holds.
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_hash <= prod ^ (prod >> 16);
    end
  end

  assign hash_out.valid      = out_valid;
  assign hash_out.hash_value = out_hash;

endmodule

`default_nettype wire

// ===== rtl/mm3_checker.sv =====
`default_nettype none

module mm3_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mm3_pkg::WORD_W-1:0] hash_value
);
  import mm3_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled hash holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value))
    else $error("hash changed or dropped while stalled");

  // One word at a time: the block is busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("word accepted while the previous one is in work");

  // Finalization runs through FIN1, FIN2 and EMIT before a hash rises.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> ##1 !$rose(out_valid))
    else $error("hash appeared too soon after a word");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind murmur3_32_key_hasher_unit mm3_checker u_mm3_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (key_in.valid),
  .in_ready   (key_in.ready),
  .out_valid  (hash_out.valid),
  .out_ready  (hash_out.ready),
  .hash_value (hash_out.hash_value)
);

`default_nettype wire

// ===== sim/tb_murmur3_32_key_hasher_unit.sv =====
`default_nettype none

module tb_murmur3_32_key_hasher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mm3_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_PAUSE = 16;

  typedef struct {
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               last;
  } key_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  mm3_in_if  key_in_bus ();
  mm3_out_if hash_out_bus ();

  logic               send_valid = 1'b0;
  logic [WORD_W-1:0]  send_data  = '0;
  logic [COUNT_W-1:0] send_count = '0;
  logic               send_last  = 1'b0;
  logic               recv_ready = 1'b0;
  logic               seed_we    = 1'b0;
  logic [WORD_W-1:0]  seed_wdata = '0;

  assign key_in_bus.valid      = send_valid;
  assign key_in_bus.data_word  = send_data;
  assign key_in_bus.byte_count = send_count;
  assign key_in_bus.last_word  = send_last;
  assign hash_out_bus.ready    = recv_ready;

  murmur3_32_key_hasher_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in_bus),
    .hash_out   (hash_out_bus),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata)
  );

  key_word_t         pending_words[$];
  logic [WORD_W-1:0] expected_hashes[$];

  // Predictor state, mirroring the block's hash, length and key boundary.
  logic [WORD_W-1:0] seed_copy    = '0;
  logic [WORD_W-1:0] hash_acc     = '0;
  logic [WORD_W-1:0] len_acc      = '0;
  logic              at_key_start = 1'b1;

  int  words_queued   = 0;
  int  words_sent     = 0;
  int  keys_sent      = 0;
  int  hashes_checked = 0;
  int  mismatches     = 0;
  int  seeds_used     = 1;
  bit  send_idle_on   = 1'b1;
  bit  recv_idle_on   = 1'b1;

  function automatic int draw_wait(input bit idle_on);
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [WORD_W-1:0] scramble_word(input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] t;
    t = k * MIX_C1;
    t = {t[16:0], t[31:17]};
    return t * MIX_C2;
  endfunction

  task automatic absorb_key_word(input key_word_t w);
    logic [COUNT_W-1:0] n;
    logic [WORD_W-1:0]  h;
    logic [WORD_W-1:0]  keep;
    if (at_key_start) begin
      hash_acc = seed_copy;
      len_acc  = '0;
    end
    // Words before the last always count as full; oversized counts saturate.
    n = w.count;
    if (n > CNT_FULL || !w.last) n = CNT_FULL;
    h = hash_acc;
    if (n == CNT_FULL) begin
      h = h ^ scramble_word(w.data);
      h = {h[18:0], h[31:19]} * MIX_M + MIX_N;
    end else if (n != CNT_NONE) begin
      keep = ~({WORD_W{1'b1}} << (8 * n));
      h = h ^ scramble_word(w.data & keep);
    end
    hash_acc     = h;
    len_acc      = len_acc + n;
    at_key_start = w.last;
    if (w.last) begin
      h = h ^ len_acc;
      h = h ^ (h >> 16);
      h = h * FIN_C1;
      h = h ^ (h >> 13);
      h = h * FIN_C2;
      h = h ^ (h >> 16);
      expected_hashes.push_back(h);
    end
  endtask

  // Driver: presents queued words and predicts each one as it is accepted.
  int        send_gap = 0;
  key_word_t sent_word;

  always @(posedge clk) begin
    if (rst) begin
      send_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (send_valid && key_in_bus.ready) begin
        sent_word.data  = send_data;
        sent_word.count = send_count;
        sent_word.last  = send_last;
        absorb_key_word(sent_word);
        words_sent++;
        if (send_last) keys_sent++;
        send_gap = draw_wait(send_idle_on);
      end
      if (send_valid && !key_in_bus.ready) begin
        // Hold the current word until it is taken.
      end else if (send_gap > 0) begin
        send_valid <= 1'b0;
        send_gap--;
      end else if (pending_words.size() > 0) begin
        sent_word = pending_words.pop_front();
        send_valid <= 1'b1;
        send_data  <= sent_word.data;
        send_count <= sent_word.count;
        send_last  <= sent_word.last;
      end else begin
        send_valid <= 1'b0;
      end
    end
  end

  // Monitor: may stall at random after each hash (if recv_idle_on) and checks it in order.
  int                recv_stall = 0;
  logic [WORD_W-1:0] want_hash;

  always @(posedge clk) begin
    if (rst) begin
      recv_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (hash_out_bus.valid && recv_ready) begin
        if (expected_hashes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] hash %08h arrived with none expected", $realtime,
                     hash_out_bus.hash_value);
        end else begin
          want_hash = expected_hashes.pop_front();
          hashes_checked++;
          if (hash_out_bus.hash_value !== want_hash) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] hash mismatch: expected %08h, got %08h", $realtime,
                       want_hash, hash_out_bus.hash_value);
          end
        end
        recv_stall = draw_wait(recv_idle_on);
      end
      if (recv_stall > 0) begin
        recv_ready <= 1'b0;
        recv_stall--;
      end else begin
        recv_ready <= 1'b1;
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (send_valid && key_in_bus.ready) || (hash_out_bus.valid && recv_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d hashes outstanding",
                 STALL_LIMIT, expected_hashes.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [WORD_W-1:0] data, input logic [COUNT_W-1:0] count,
                           input logic last);
    key_word_t w;
    w.data  = data;
    w.count = count;
    w.last  = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic [WORD_W-1:0] random_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_key();
    int                 len;
    logic [COUNT_W-1:0] n;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    for (int i = 0; i < len - 1; i++) begin
      // Non-final words sometimes carry a bogus count that must be ignored.
      n = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(0, 7)) : CNT_FULL;
      push_word(random_data(), n, 1'b0);
    end
    n = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(5, 7))
                                    : COUNT_W'($urandom_range(0, 4));
    push_word(random_data(), n, 1'b1);
  endtask

  task automatic queue_directed_keys();
    // Empty key: only the finalizer runs.
    push_word($urandom, CNT_NONE, 1'b1);
    // Single-word keys for every nonzero count, including saturating ones.
    for (int c = 1; c < 8; c++)
      push_word((c % 2 == 1) ? '1 : '0, COUNT_W'(c), 1'b1);
    // Bogus counts on non-final words, garbage above a three-byte tail.
    push_word('0, CNT_NONE, 1'b0);
    push_word('1, 3'd7, 1'b0);
    push_word(32'hdead_beef, 3'd3, 1'b1);
    // Full words followed by a zero-byte final word.
    push_word(32'h8000_0001, CNT_FULL, 1'b0);
    push_word(32'h7fff_fffe, 3'd2, 1'b0);
    push_word('1, CNT_NONE, 1'b1);
    // A one-byte tail after a full word.
    push_word(32'h0403_0201, CNT_FULL, 1'b0);
    push_word(32'hffff_ff80, 3'd1, 1'b1);
  endtask

  task automatic wait_until_drained();
    while (words_sent != words_queued || expected_hashes.size() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] seed, input bit send_idle,
                           input bit recv_idle, input int word_target);
    int start;
    @(posedge clk);
    seed_we    <= 1'b1;
    seed_wdata <= seed;
    seed_copy = seed;
    seeds_used++;
    @(posedge clk);
    seed_we <= 1'b0;
    @(negedge clk);
    send_idle_on = send_idle;
    recv_idle_on = recv_idle;
    start = words_queued;
    while (words_queued - start < word_target) queue_random_key();
    wait_until_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed keys under the reset seed.
    queue_directed_keys();
    wait_until_drained();

    run_phase(32'hffff_ffff, 1'b1, 1'b1, 200);
    run_phase(32'h0000_0000, 1'b0, 1'b0, 200);
    run_phase(32'h8000_0000, 1'b1, 1'b0, 200);
    run_phase($urandom,      1'b0, 1'b1, 200);
    run_phase(32'h0000_0001, 1'b1, 1'b1, 200);
    run_phase($urandom,      1'b1, 1'b1, 200);

    if (expected_hashes.size() != 0) begin
      mismatches++;
      $display("%0d expected hashes never arrived", expected_hashes.size());
    end
    $display("Hashed %0d keys from %0d words under %0d seed values.", keys_sent,
             words_sent, seeds_used);
    $display("%0d hashes compared, %0d mismatches.", hashes_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/mm3_pkg.sv
rtl/mm3_if.sv
rtl/mm3_mul.sv
rtl/murmur3_32_key_hasher_unit.sv
rtl/mm3_checker.sv
sim/tb_murmur3_32_key_hasher_unit.sv
